// ----- rtl/core/can_fmq_pkg.sv -----
// ----------------------------------------------------------------------------
// can_fmq_pkg
// Shared types, codes and helpers of the multicast CAN frame queues.
// ----------------------------------------------------------------------------
package can_fmq_pkg;

   // default sizing
   localparam int DEF_PORTS       = 8;
   localparam int DEF_QUEUE_DEPTH = 1024;
   localparam int DEF_BUSES       = 16;

   // configuration register indexes
   localparam logic [1:0] CFG_ENABLE   = 2'd0;
   localparam logic [1:0] CFG_BUS_MAP  = 2'd1;
   localparam logic [1:0] CFG_RECV_OWN = 2'd2;

   // request opcodes
   localparam logic [1:0] OP_SEND  = 2'd0;
   localparam logic [1:0] OP_RECV  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_DISABLED = 2'd2;

   // command kinds handed from front to back
   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_SEND  = 2'd1;
   localparam logic [1:0] KIND_RECV  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   typedef struct packed {
      logic [7:0]  enable;
      logic [31:0] bus_map;
      logic [7:0]  recv_own;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [2:0]  port;
      logic [3:0]  bus;
      logic [31:0] frame_id;
      logic [3:0]  frame_len;
      logic [63:0] frame_data;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] rx_frame_id;
      logic [3:0]  rx_frame_len;
      logic [63:0] rx_frame_data;
      logic [7:0]  delivered_mask;
      logic [7:0]  overwrite_mask;
   } rsp_type;

   // ports 8 and up have no register bits: disabled, bus 0, no receive-own
   function automatic logic port_enabled(cfg_type cfg, logic [3:0] p);
      return p[3] ? 1'b0 : cfg.enable[p[2:0]];
   endfunction

   function automatic logic [3:0] port_bus(cfg_type cfg, logic [3:0] p);
      return p[3] ? 4'd0 : cfg.bus_map[{p[2:0], 2'b00} +: 4];
   endfunction

   function automatic logic port_recv_own(cfg_type cfg, logic [3:0] p);
      return p[3] ? 1'b0 : cfg.recv_own[p[2:0]];
   endfunction

endpackage

// ----- rtl/core/can_fmq_ram.sv -----
// ----------------------------------------------------------------------------
// can_fmq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module can_fmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/can_fmq_fifo.sv -----
// ----------------------------------------------------------------------------
// can_fmq_fifo
// Small register-based queue used between the front, back and response side.
// ----------------------------------------------------------------------------
module can_fmq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/can_fmq_front.sv -----
// ----------------------------------------------------------------------------
// can_fmq_front
// Accepts request transactions, checks port and bus, and queues commands.
// ----------------------------------------------------------------------------
module can_fmq_front #(
   parameter int PORTS = can_fmq_pkg::DEF_PORTS,
   parameter int BUSES = can_fmq_pkg::DEF_BUSES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  can_fmq_pkg::cfg_type cfg,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_opcode,
   input  logic [2:0]           req_port,
   input  logic [31:0]          req_frame_id,
   input  logic [3:0]           req_frame_len,
   input  logic [63:0]          req_frame_data,
   output logic                 cmd_valid,
   output can_fmq_pkg::cmd_type cmd,
   input  logic                 cmd_pop
);

   import can_fmq_pkg::*;

   cmd_type    cmd_new;
   logic [3:0] port_x;
   logic [3:0] sender_bus;
   logic       cmd_empty;

   assign port_x     = 4'(req_port);
   assign sender_bus = port_bus(cfg, port_x);

   // classify the request
   always_comb begin
      cmd_new            = '0;
      cmd_new.port       = req_port;
      cmd_new.frame_id   = req_frame_id;
      cmd_new.frame_len  = req_frame_len;
      cmd_new.frame_data = req_frame_data;
      cmd_new.kind       = KIND_REPLY;
      cmd_new.status     = STATUS_OK;
      if (req_opcode == OP_NONE) begin
         cmd_new.kind = KIND_REPLY;
      end else if (32'(req_port) >= PORTS) begin
         cmd_new.status = STATUS_DISABLED;
      end else if (req_opcode == OP_CLEAR) begin
         cmd_new.kind = KIND_CLEAR;
      end else if (!port_enabled(cfg, port_x)) begin
         cmd_new.status = STATUS_DISABLED;
      end else if (req_opcode == OP_RECV) begin
         cmd_new.kind = KIND_RECV;
      end else if (32'(sender_bus) >= BUSES) begin
         cmd_new.status = STATUS_DISABLED;
      end else begin
         cmd_new.kind = KIND_SEND;
         cmd_new.bus  = sender_bus;
      end
   end

   // command queue towards the back end
   can_fmq_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_new),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

// ----- rtl/core/can_fmq_back.sv -----
// ----------------------------------------------------------------------------
// can_fmq_back
// Executes queued commands: multicast send over all ports, receive, clear, reply.
// ----------------------------------------------------------------------------
module can_fmq_back #(
   parameter int PORTS       = can_fmq_pkg::DEF_PORTS,
   parameter int QUEUE_DEPTH = can_fmq_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  can_fmq_pkg::cfg_type cfg,
   input  logic                 cmd_valid,
   input  can_fmq_pkg::cmd_type cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output can_fmq_pkg::rsp_type rsp
);

   import can_fmq_pkg::*;

   localparam int PW = $clog2(PORTS);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int MD = PORTS * QUEUE_DEPTH;
   localparam int AW = $clog2(MD);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_REPLY = 3'd1;
   localparam logic [2:0] ST_CLEAR = 3'd2;
   localparam logic [2:0] ST_SEND  = 3'd3;
   localparam logic [2:0] ST_RECV  = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;

   logic [2:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [PW-1:0] p_ff, p_in;
   logic [7:0]    dmask_ff, dmask_in;
   logic [7:0]    omask_ff, omask_in;
   logic [IW-1:0] rd_idx_ff [PORTS];
   logic [IW-1:0] rd_idx_in [PORTS];
   logic [IW-1:0] wr_idx_ff [PORTS];
   logic [IW-1:0] wr_idx_in [PORTS];

   logic [PW-1:0] sel;
   logic [3:0]    p_x;
   logic [IW-1:0] rd_cur, wr_cur, rd_nxt, wr_nxt;
   logic          eligible, drop;
   logic [7:0]    p_bit;
   logic [AW-1:0] mem_addr;
   logic          mem_we, mem_re;
   logic [35:0]   hdr_rd;
   logic [63:0]   payload_rd;

   // queue pointers of the selected port
   assign sel    = (state_ff == ST_SEND) ? p_ff : PW'(cmd_ff.port);
   assign p_x    = 4'(p_ff);
   assign rd_cur = rd_idx_ff[sel];
   assign wr_cur = wr_idx_ff[sel];
   assign rd_nxt = (rd_cur == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_cur + 1'b1;
   assign wr_nxt = (wr_cur == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_cur + 1'b1;
   assign drop   = (rd_cur == wr_nxt);
   assign p_bit  = p_x[3] ? 8'd0 : (8'd1 << p_x[2:0]);

   // does the port under scan take the frame
   assign eligible = port_enabled(cfg, p_x)
                  && (port_bus(cfg, p_x) == cmd_ff.bus)
                  && !((p_x == 4'(cmd_ff.port))
                       && !port_recv_own(cfg, 4'(cmd_ff.port)));

   // frame store access
   assign mem_addr = AW'(32'(sel) * QUEUE_DEPTH)
                   + AW'((state_ff == ST_SEND) ? wr_cur : rd_cur);
   assign mem_we   = (state_ff == ST_SEND) && eligible;
   assign mem_re   = (state_ff == ST_RECV) && (rd_cur != wr_cur);

   can_fmq_ram #(
      .WIDTH (36),
      .DEPTH (MD)
   ) u_header_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data ({cmd_ff.frame_len, cmd_ff.frame_id}),
      .rd_en   (mem_re),
      .rd_addr (mem_addr),
      .rd_data (hdr_rd)
   );

   can_fmq_ram #(
      .WIDTH (64),
      .DEPTH (MD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (cmd_ff.frame_data),
      .rd_en   (mem_re),
      .rd_addr (mem_addr),
      .rd_data (payload_rd)
   );

   // command sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      p_in      = p_ff;
      dmask_in  = dmask_ff;
      omask_in  = omask_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               p_in     = '0;
               dmask_in = '0;
               omask_in = '0;
               unique case (cmd.kind)
                  KIND_SEND:  state_in = ST_SEND;
                  KIND_RECV:  state_in = ST_RECV;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  default:    state_in = ST_REPLY;
               endcase
            end
         end
         ST_REPLY: begin
            rsp_push   = 1'b1;
            rsp.status = cmd_ff.status;
            state_in   = ST_IDLE;
         end
         ST_CLEAR: begin
            rd_idx_in[sel] = '0;
            wr_idx_in[sel] = '0;
            rsp_push       = 1'b1;
            rsp.status     = STATUS_OK;
            state_in       = ST_IDLE;
         end
         ST_SEND: begin
            if (eligible) begin
               wr_idx_in[sel] = wr_nxt;
               dmask_in       = dmask_ff | p_bit;
               if (drop) begin
                  rd_idx_in[sel] = rd_nxt;
                  omask_in       = omask_ff | p_bit;
               end
            end
            if (p_ff == PW'(PORTS - 1)) begin
               rsp_push           = 1'b1;
               rsp.status         = STATUS_OK;
               rsp.delivered_mask = dmask_in;
               rsp.overwrite_mask = omask_in;
               state_in           = ST_IDLE;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         ST_RECV: begin
            if (rd_cur == wr_cur) begin
               rsp_push   = 1'b1;
               rsp.status = STATUS_EMPTY;
               state_in   = ST_IDLE;
            end else begin
               rd_idx_in[sel] = rd_nxt;
               state_in       = ST_RDATA;
            end
         end
         ST_RDATA: begin
            rsp_push          = 1'b1;
            rsp.status        = STATUS_OK;
            rsp.rx_frame_id   = hdr_rd[31:0];
            rsp.rx_frame_len  = hdr_rd[35:32];
            rsp.rx_frame_data = payload_rd;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_ff     <= '0;
         for (int i = 0; i < PORTS; i++) begin
            rd_idx_ff[i] <= '0;
            wr_idx_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         p_ff      <= p_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
      end
   end

   // command payload and send masks
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      dmask_ff <= dmask_in;
      omask_ff <= omask_in;
   end

endmodule

// ----- rtl/core/can_frame_multicast_queues.sv -----
// ----------------------------------------------------------------------------
// can_frame_multicast_queues
// Per-port CAN frame ring queues with multicast send, receive and clear.
// ----------------------------------------------------------------------------
// Flow: a request waits in the command queue until the back end is idle and
//   the response queue has room; the response is then pushed into the
//   response queue. Send scans the ports one at a time on the single frame
//   memory port; receive of a frame reads the frame store before replying.
// Queueing: the back end runs one command at a time; command and
//   response queues hold 2 each.
// Reset: synchronous; clears configuration, queue pointers and both queues.
//   Frame memory is not cleared, there is no clearing pass.
module can_frame_multicast_queues #(
   parameter int PORTS       = can_fmq_pkg::DEF_PORTS,
   parameter int QUEUE_DEPTH = can_fmq_pkg::DEF_QUEUE_DEPTH,
   parameter int BUSES       = can_fmq_pkg::DEF_BUSES
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_port,
   input  logic [31:0] req_frame_id,
   input  logic [3:0]  req_frame_len,
   input  logic [63:0] req_frame_data,
   // response channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_rx_frame_id,
   output logic [3:0]  rsp_rx_frame_len,
   output logic [63:0] rsp_rx_frame_data,
   output logic [7:0]  rsp_delivered_mask,
   output logic [7:0]  rsp_overwrite_mask,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   import can_fmq_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid, cmd_pop;
   rsp_type rsp_new, rsp_head;
   logic    rsp_push, rsp_full;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CFG_ENABLE:   cfg_in.enable   = csr_wdata[7:0];
            CFG_BUS_MAP:  cfg_in.bus_map  = csr_wdata;
            CFG_RECV_OWN: cfg_in.recv_own = csr_wdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and queue
   can_fmq_front #(
      .PORTS (PORTS),
      .BUSES (BUSES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_port       (req_port),
      .req_frame_id   (req_frame_id),
      .req_frame_len  (req_frame_len),
      .req_frame_data (req_frame_data),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // back end: queue pointers and frame store
   can_fmq_back #(
      .PORTS       (PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new)
   );

   // response queue
   can_fmq_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head),
      .empty   (rsp_empty)
   );

   assign rsp_status         = rsp_head.status;
   assign rsp_rx_frame_id    = rsp_head.rx_frame_id;
   assign rsp_rx_frame_len   = rsp_head.rx_frame_len;
   assign rsp_rx_frame_data  = rsp_head.rx_frame_data;
   assign rsp_delivered_mask = rsp_head.delivered_mask;
   assign rsp_overwrite_mask = rsp_head.overwrite_mask;

endmodule
